### hdl/sac_pkg.sv
// shared types and constants of the per-id stall accumulator
// no dependencies; used by sac_apb, per_id_stall_accumulator_unit and the testbench
`default_nettype none

package sac_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int ADDR_W        = $clog2(TABLE_ENTRIES);

    localparam int ID_W      = 10;
    localparam int TIME_W    = 64;
    localparam int DELTA_W   = 40;
    localparam int COUNT_W   = 32;
    localparam int STATUS_W  = 3;
    localparam int MAX_W     = 40;

    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 136;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 64;

    localparam logic [MAX_W-1:0] MAX_STALL_RESET = 40'd30000000000;
    localparam logic [PADDR_W-1:0] REG_MAX_STALL = 4'h0;

    localparam logic ACT_BEGIN = 1'b0;
    localparam logic ACT_END   = 1'b1;

    localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BEGIN    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_BEGIN = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ADDED    = 3'd4;

    typedef struct packed {
        logic               valid;
        logic [TIME_W-1:0]  start;
        logic [TIME_W-1:0]  total;
        logic [COUNT_W-1:0] count;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    function automatic logic [ADDR_W-1:0] id_to_addr(input logic [ID_W-1:0] id);
        return ADDR_W'(id);
    endfunction

    function automatic logic id_ignored(input logic [ID_W-1:0] id);
        return (id == '0) || (32'(id) >= 32'(TABLE_ENTRIES));
    endfunction

endpackage

`default_nettype wire

### hdl/sac_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module sac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### hdl/sac_apb.sv
// apb configuration register of the stall accumulator (stall limit)
// depends on sac_pkg
`default_nettype none

module sac_apb (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [sac_pkg::PADDR_W-1:0]       paddr,
    input  wire logic [sac_pkg::PDATA_W-1:0]       pwdata,
    output logic      [sac_pkg::PDATA_W-1:0]       prdata,
    output logic                                   pready,
    output logic      [sac_pkg::MAX_W-1:0]         o_max_stall_ns
);

    logic [sac_pkg::MAX_W-1:0] r_max_stall;
    logic                      sel_max;

    // registers sit on 8-byte boundaries
    assign sel_max = (paddr[3] == sac_pkg::REG_MAX_STALL[3]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_stall <= sac_pkg::MAX_STALL_RESET;
        end else if (psel && penable && pwrite && pready && sel_max) begin
            r_max_stall <= pwdata[sac_pkg::MAX_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (sel_max) begin
            prdata = sac_pkg::PDATA_W'(r_max_stall);
        end
    end

    assign o_max_stall_ns = r_max_stall;

endmodule

`default_nettype wire

### hdl/per_id_stall_accumulator_unit.sv
// per-id stall accumulator: stream in begin/end events, stream out per-id totals
// depends on sac_pkg, sac_ram, sac_apb
//
// input transaction: tuser = action (0 begin, 1 end); tdata = task_id, now_ns.
// output transaction: tuser = status; tdata = delta_ns, total_ns, total_count.
// one result per input, in order. the per-id table (start, total, count) lives
// in one ram read-modify-written per event: read on accept, delta and limit
// compare in the next cycle, add and write-back in the update step once the
// output register is free. a new event is accepted only after the write-back.
// the result goes through the lookup and update registers to the output register.
// the output register frees the input side: a new event is taken while a
// result waits; a further result waits in the update step while the
// receiver stalls, and s_axis_tready stays low meanwhile.
// reset: a clearing pass writes all TABLE_ENTRIES (1024) rows to zero, one per
// cycle, with s_axis_tready low; the stall limit returns to 30 s.
// the user must write the limit register over apb only while the block is idle; the block itself does not enforce it.
`default_nettype none

module per_id_stall_accumulator_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // slave stream
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [sac_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // task_id, now_ns, pad
    input  wire logic                                s_axis_tuser,  // action
    // master stream
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic      [sac_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // delta_ns, total_ns, total_count
    output logic      [sac_pkg::STATUS_W-1:0]        m_axis_tuser,  // status
    // configuration
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [sac_pkg::PADDR_W-1:0]         paddr,
    input  wire logic [sac_pkg::PDATA_W-1:0]         pwdata,
    output logic      [sac_pkg::PDATA_W-1:0]         prdata,
    output logic                                     pready
);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_LOOK, S_UPD} t_state;

    t_state                             r_state, n_state;
    logic [sac_pkg::ADDR_W-1:0]         r_clr_addr, n_clr_addr;
    logic                               r_act, n_act;
    logic                               r_ign, n_ign;
    logic [sac_pkg::ADDR_W-1:0]         r_addr, n_addr;
    logic [sac_pkg::TIME_W-1:0]         r_now, n_now;
    sac_pkg::t_entry                    r_entry, n_entry;
    logic [sac_pkg::TIME_W-1:0]         r_delta, n_delta;
    logic                               r_over, n_over;
    logic                               r_ovalid, n_ovalid;
    logic [sac_pkg::STATUS_W-1:0]       r_ostatus, n_ostatus;
    logic [sac_pkg::DELTA_W-1:0]        r_odelta, n_odelta;
    logic [sac_pkg::TIME_W-1:0]         r_ototal, n_ototal;
    logic [sac_pkg::COUNT_W-1:0]        r_ocount, n_ocount;

    logic                               ram_we;
    logic [sac_pkg::ADDR_W-1:0]         ram_waddr;
    sac_pkg::t_entry                    ram_wentry;
    logic                               ram_re;
    logic [sac_pkg::ENTRY_W-1:0]        ram_rdata;
    sac_pkg::t_entry                    rd_entry;
    logic [sac_pkg::MAX_W-1:0]          max_stall;
    logic [sac_pkg::ID_W-1:0]           in_id;

    assign in_id    = s_axis_tdata[sac_pkg::ID_W-1:0];
    assign rd_entry = sac_pkg::t_entry'(ram_rdata);

    sac_apb u_apb (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_max_stall_ns (max_stall)
    );

    sac_ram #(
        .WIDTH (sac_pkg::ENTRY_W),
        .DEPTH (sac_pkg::TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wentry),
        .i_re    (ram_re),
        .i_raddr (sac_pkg::id_to_addr(in_id)),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_act      = r_act;
        n_ign      = r_ign;
        n_addr     = r_addr;
        n_now      = r_now;
        n_entry    = r_entry;
        n_delta    = r_delta;
        n_over     = r_over;
        n_ovalid   = r_ovalid;
        n_ostatus  = r_ostatus;
        n_odelta   = r_odelta;
        n_ototal   = r_ototal;
        n_ocount   = r_ocount;
        ram_we     = 1'b0;
        ram_waddr  = r_addr;
        ram_wentry = r_entry;
        ram_re     = 1'b0;

        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wentry = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == sac_pkg::ADDR_W'(sac_pkg::TABLE_ENTRIES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    ram_re  = 1'b1;
                    n_act   = s_axis_tuser;
                    n_ign   = sac_pkg::id_ignored(in_id);
                    n_addr  = sac_pkg::id_to_addr(in_id);
                    n_now   = s_axis_tdata[sac_pkg::ID_W +: sac_pkg::TIME_W];
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_entry = rd_entry;
                n_delta = r_now - rd_entry.start;
                n_over  = (n_delta > sac_pkg::TIME_W'(max_stall));
                n_state = S_UPD;
            end
            S_UPD: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_odelta = '0;
                    n_ototal = r_entry.total;
                    n_ocount = r_entry.count;
                    n_state  = S_IDLE;
                    if (r_ign) begin
                        n_ostatus = sac_pkg::ST_IGNORED;
                        n_ototal  = '0;
                        n_ocount  = '0;
                    end else if (r_act == sac_pkg::ACT_BEGIN) begin
                        n_ostatus        = sac_pkg::ST_BEGIN;
                        ram_we           = 1'b1;
                        ram_wentry.valid = 1'b1;
                        ram_wentry.start = r_now;
                    end else if (!r_entry.valid) begin
                        n_ostatus = sac_pkg::ST_NO_BEGIN;
                    end else if (r_over) begin
                        n_ostatus        = sac_pkg::ST_DROPPED;
                        ram_we           = 1'b1;
                        ram_wentry.valid = 1'b0;
                    end else begin
                        n_ostatus        = sac_pkg::ST_ADDED;
                        n_odelta         = r_delta[sac_pkg::DELTA_W-1:0];
                        n_ototal         = r_entry.total + r_delta;
                        n_ocount         = r_entry.count + 1'b1;
                        ram_we           = 1'b1;
                        ram_wentry.valid = 1'b0;
                        ram_wentry.total = n_ototal;
                        ram_wentry.count = n_ocount;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_ovalid   <= n_ovalid;
        end
        r_act     <= n_act;
        r_ign     <= n_ign;
        r_addr    <= n_addr;
        r_now     <= n_now;
        r_entry   <= n_entry;
        r_delta   <= n_delta;
        r_over    <= n_over;
        r_ostatus <= n_ostatus;
        r_odelta  <= n_odelta;
        r_ototal  <= n_ototal;
        r_ocount  <= n_ocount;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_ostatus;
    assign m_axis_tdata  = {r_ocount, r_ototal, r_odelta};

    a_accept_to_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == S_LOOK))
        else $error("accepted transaction did not start a table lookup");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_LOOK) |-> !ram_we)
        else $error("table written outside clear or update");

    a_ignored_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == sac_pkg::ST_IGNORED) |-> (m_axis_tdata == '0))
        else $error("ignored id returned nonzero totals");

    a_delta_only_added: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != sac_pkg::ST_ADDED) |-> (r_odelta == '0))
        else $error("delta reported on a transaction that added nothing");

endmodule

`default_nettype wire

### verif/tb_per_id_stall_accumulator_unit.sv
// testbench for per_id_stall_accumulator_unit: directed and random begin/end events
// checked against a per-id totals predictor; needs sac_pkg and the block's rtl
`timescale 1ns / 100ps

module tb_per_id_stall_accumulator_unit;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int PHASE_ITEMS    = 180;
    localparam logic [sac_pkg::PADDR_W-1:0] REG_UNMAPPED = 4'h8;

    typedef struct packed {
        logic [sac_pkg::STATUS_W-1:0] status;
        logic [sac_pkg::DELTA_W-1:0]  delta;
        logic [sac_pkg::TIME_W-1:0]   total;
        logic [sac_pkg::COUNT_W-1:0]  count;
    } t_stall_result;

    class stall_ledger;
        logic [sac_pkg::MAX_W-1:0]   limit;
        bit                          open_q[sac_pkg::TABLE_ENTRIES];
        logic [sac_pkg::TIME_W-1:0]  start_ts[sac_pkg::TABLE_ENTRIES];
        logic [sac_pkg::TIME_W-1:0]  total_ns[sac_pkg::TABLE_ENTRIES];
        logic [sac_pkg::COUNT_W-1:0] total_cnt[sac_pkg::TABLE_ENTRIES];
        t_stall_result               expected_totals[$];
        int                          errors;

        function new();
            limit  = sac_pkg::MAX_STALL_RESET;
            errors = 0;
            for (int i = 0; i < sac_pkg::TABLE_ENTRIES; i++) begin
                open_q[i]    = 1'b0;
                start_ts[i]  = '0;
                total_ns[i]  = '0;
                total_cnt[i] = '0;
            end
        endfunction

        function void set_limit(logic [sac_pkg::MAX_W-1:0] value);
            limit = value;
        endfunction

        function int pending();
            return expected_totals.size();
        endfunction

        function void note_event(bit action, logic [sac_pkg::ID_W-1:0] id,
                                 logic [sac_pkg::TIME_W-1:0] now);
            t_stall_result              r;
            logic [sac_pkg::TIME_W-1:0] span;
            r = '0;
            if (id == '0 || 32'(id) >= 32'(sac_pkg::TABLE_ENTRIES)) begin
                r.status = sac_pkg::ST_IGNORED;
                expected_totals.push_back(r);
                return;
            end
            if (action == sac_pkg::ACT_BEGIN) begin
                open_q[id]   = 1'b1;
                start_ts[id] = now;
                r.status     = sac_pkg::ST_BEGIN;
            end else if (!open_q[id]) begin
                r.status = sac_pkg::ST_NO_BEGIN;
            end else begin
                span       = now - start_ts[id];
                open_q[id] = 1'b0;
                if (span > {24'b0, limit}) begin
                    r.status = sac_pkg::ST_DROPPED;
                end else begin
                    total_ns[id]  = total_ns[id] + span;
                    total_cnt[id] = total_cnt[id] + 32'd1;
                    r.delta       = span[sac_pkg::DELTA_W-1:0];
                    r.status      = sac_pkg::ST_ADDED;
                end
            end
            r.total = total_ns[id];
            r.count = total_cnt[id];
            expected_totals.push_back(r);
        endfunction

        function void check_result(logic [sac_pkg::STATUS_W-1:0] st,
                                   logic [sac_pkg::DELTA_W-1:0] dl,
                                   logic [sac_pkg::TIME_W-1:0] tot,
                                   logic [sac_pkg::COUNT_W-1:0] cnt);
            t_stall_result e;
            if (expected_totals.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %0d",
                         $time, st);
                errors++;
                return;
            end
            e = expected_totals.pop_front();
            if (st !== e.status) begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, st);
                errors++;
            end
            if (dl !== e.delta) begin
                $display("%0t: delta_ns expected %0h actual %0h", $time, e.delta, dl);
                errors++;
            end
            if (tot !== e.total) begin
                $display("%0t: total_ns expected %0h actual %0h", $time, e.total, tot);
                errors++;
            end
            if (cnt !== e.count) begin
                $display("%0t: total_count expected %0h actual %0h", $time, e.count, cnt);
                errors++;
            end
        endfunction
    endclass

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               s_axis_tvalid;
    logic                               s_axis_tready;
    logic [sac_pkg::IN_TDATA_W-1:0]     s_axis_tdata;   // task_id, now_ns, pad
    logic                               s_axis_tuser;   // action
    logic                               m_axis_tvalid;
    logic                               m_axis_tready;
    logic [sac_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;   // delta_ns, total_ns, total_count
    logic [sac_pkg::STATUS_W-1:0]       m_axis_tuser;   // status
    logic                               psel;
    logic                               penable;
    logic                               pwrite;
    logic [sac_pkg::PADDR_W-1:0]        paddr;
    logic [sac_pkg::PDATA_W-1:0]        pwdata;
    logic [sac_pkg::PDATA_W-1:0]        prdata;
    logic                               pready;

    stall_ledger                ledger;
    bit                         tx_quiet;
    bit                         rx_quiet;
    logic [sac_pkg::TIME_W-1:0] cur_limit;
    bit                         gen_open[sac_pkg::TABLE_ENTRIES];
    logic [sac_pkg::TIME_W-1:0] gen_start[sac_pkg::TABLE_ENTRIES];
    int                         quiet_cycles;

    per_id_stall_accumulator_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int idle_draw(bit quiet);
        return quiet ? 0 : $urandom_range(0, 13);
    endfunction

    // watchdog on handshake activity
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable && pready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_event(bit action, logic [sac_pkg::ID_W-1:0] id,
                              logic [sac_pkg::TIME_W-1:0] now);
        int gap;
        gap = idle_draw(tx_quiet);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= action;
        s_axis_tdata  <= {6'b0, now, id};
        do @(posedge i_clk); while (!s_axis_tready);
        ledger.note_event(action, id, now);
        if (id != '0) begin
            gen_open[id] = (action == sac_pkg::ACT_BEGIN);
            if (action == sac_pkg::ACT_BEGIN) gen_start[id] = now;
        end
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (ledger.pending() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [sac_pkg::PADDR_W-1:0] addr,
                             logic [sac_pkg::PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == sac_pkg::REG_MAX_STALL) begin
            ledger.set_limit(data[sac_pkg::MAX_W-1:0]);
            cur_limit = {24'b0, data[sac_pkg::MAX_W-1:0]};
        end
        @(posedge i_clk);
    endtask

    task automatic random_event(output bit counted);
        bit                         action;
        logic [sac_pkg::ID_W-1:0]   id;
        logic [sac_pkg::TIME_W-1:0] now;
        logic [sac_pkg::TIME_W-1:0] span;
        if ($urandom_range(0, 99) < 12) begin
            action = 1'($urandom_range(0, 1));
            id     = sac_pkg::ID_W'($urandom_range(0, sac_pkg::TABLE_ENTRIES - 1));
            now    = {$urandom, $urandom};
        end else begin
            id = ($urandom_range(0, 4) == 0)
                 ? sac_pkg::ID_W'($urandom_range(16, sac_pkg::TABLE_ENTRIES - 1))
                 : sac_pkg::ID_W'($urandom_range(1, 15));
            if (gen_open[id] && $urandom_range(0, 9) < 8) begin
                action = sac_pkg::ACT_END;
                case ($urandom_range(0, 5))
                    0: span = 64'($urandom_range(0, 50));
                    1: span = cur_limit;
                    2: span = cur_limit + 64'd1;
                    3: span = {$urandom, $urandom} % (cur_limit + 64'd1);
                    4: span = {$urandom, $urandom};
                    default: span = cur_limit - 64'd1;
                endcase
                now = gen_start[id] + span;
            end else begin
                action = sac_pkg::ACT_BEGIN;
                now    = $urandom_range(0, 1) ? {$urandom, $urandom} : 64'($urandom);
            end
        end
        send_event(action, id, now);
        counted = (id != '0);
    endtask

    // result side: random stalls, checks every accepted transaction
    initial begin
        int stall;
        m_axis_tready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = idle_draw(rx_quiet);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            ledger.check_result(m_axis_tuser, m_axis_tdata[39:0], m_axis_tdata[103:40],
                                m_axis_tdata[135:104]);
        end
    end

    initial begin
        logic [sac_pkg::MAX_W-1:0] phase_limit[5];
        bit                        counted;
        int                        done;
        ledger        = new();
        cur_limit     = {24'b0, sac_pkg::MAX_STALL_RESET};
        quiet_cycles  = 0;
        tx_quiet      = 1'b0;
        rx_quiet      = 1'b0;
        for (int i = 0; i < sac_pkg::TABLE_ENTRIES; i++) begin
            gen_open[i]  = 1'b0;
            gen_start[i] = '0;
        end
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset limit
        send_event(sac_pkg::ACT_BEGIN, 10'd1, 64'd100);
        send_event(sac_pkg::ACT_END,   10'd1, 64'd150);
        send_event(sac_pkg::ACT_END,   10'd2, 64'd500);
        send_event(sac_pkg::ACT_BEGIN, 10'd0, 64'd7);
        send_event(sac_pkg::ACT_END,   10'd0, '1);
        send_event(sac_pkg::ACT_BEGIN, 10'd1023, '1);
        send_event(sac_pkg::ACT_END,   10'd1023, 64'd5);
        send_event(sac_pkg::ACT_BEGIN, 10'd3, 64'd1000);
        send_event(sac_pkg::ACT_END,   10'd3, 64'd500);
        send_event(sac_pkg::ACT_BEGIN, 10'd4, 64'd100);
        send_event(sac_pkg::ACT_BEGIN, 10'd4, 64'd200);
        send_event(sac_pkg::ACT_END,   10'd4, 64'd250);
        send_event(sac_pkg::ACT_BEGIN, 10'd5, 64'd0);
        send_event(sac_pkg::ACT_END,   10'd5, 64'd30000000001);
        send_event(sac_pkg::ACT_BEGIN, 10'd512, 64'h8000_0000_0000_0000);
        send_event(sac_pkg::ACT_END,   10'd512, 64'h8000_0006_FC23_AC00);
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        send_event(sac_pkg::ACT_BEGIN, 10'd6, 64'd10);
        send_event(sac_pkg::ACT_END,   10'd6, 64'd20);
        send_event(sac_pkg::ACT_BEGIN, 10'd6, 64'd30);
        send_event(sac_pkg::ACT_END,   10'd6, 64'd45);
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        wait_idle();

        // limit extremes
        apb_write(sac_pkg::REG_MAX_STALL, 64'd0);
        send_event(sac_pkg::ACT_BEGIN, 10'd7, 64'd900);
        send_event(sac_pkg::ACT_END,   10'd7, 64'd900);
        send_event(sac_pkg::ACT_BEGIN, 10'd7, 64'd900);
        send_event(sac_pkg::ACT_END,   10'd7, 64'd901);
        wait_idle();
        apb_write(sac_pkg::REG_MAX_STALL, 64'h0000_00FF_FFFF_FFFF);
        apb_write(REG_UNMAPPED, {$urandom, $urandom});
        send_event(sac_pkg::ACT_BEGIN, 10'd8, 64'd0);
        send_event(sac_pkg::ACT_END,   10'd8, 64'h0000_00FF_FFFF_FFFF);
        send_event(sac_pkg::ACT_BEGIN, 10'd8, 64'd0);
        send_event(sac_pkg::ACT_END,   10'd8, 64'h0000_0100_0000_0000);
        wait_idle();

        // random phases, one limit each
        phase_limit[0] = sac_pkg::MAX_STALL_RESET;
        phase_limit[1] = 40'd1000;
        phase_limit[2] = sac_pkg::MAX_W'({$urandom, $urandom});
        phase_limit[3] = '1;
        phase_limit[4] = '0;
        for (int p = 0; p < 5; p++) begin
            apb_write(sac_pkg::REG_MAX_STALL, {24'b0, phase_limit[p]});
            done = 0;
            while (done < PHASE_ITEMS) begin
                if (done % 40 == 0) begin
                    tx_quiet = ($urandom_range(0, 3) == 0);
                    rx_quiet = ($urandom_range(0, 3) == 0);
                end
                random_event(counted);
                if (counted) done++;
            end
            wait_idle();
        end

        repeat (10) @(posedge i_clk);
        if (ledger.errors == 0 && ledger.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
